/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master byte engine
// Op codes, phase codes and the result record passed from the sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int BYTE_BITS = 8;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // active command uses the op codes, with the tick code meaning idle
   localparam logic [2:0] CMD_IDLE = OP_TICK;

   localparam logic [1:0] PH_SETUP = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;

   // bit index of the acknowledge clock
   localparam logic [3:0] ACK_BIT = 4'(BYTE_BITS);

   localparam logic [7:0] TICKS_RESET = 8'd1;

   typedef struct packed {
      logic       cmd_rejected;
      logic       ack_missing;
      logic [7:0] rd_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } rsp_type;

endpackage

/* rtl/core/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// i2cm_seq: command and phase sequencer
// Holds the bus state, steps it once per accepted item and forms the result.
// ----------------------------------------------------------------------------
module i2cm_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_accept,
   input  logic [2:0]       op,
   input  logic [7:0]       wr_data,
   input  logic             send_ack,
   input  logic             sda_in,
   input  logic [7:0]       phase_ticks,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;

   logic [2:0] cmd_ff,   cmd_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] bit_ff,   bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_ff,  tick_in;
   logic [1:0] lines_ff, lines_in;
   logic       ackc_ff,  ackc_in;
   logic       acks_ff,  acks_in;
   logic [7:0] rdh_ff,   rdh_in;

   logic [7:0] limit;
   logic       is_cmd;
   logic       byte_cmd;
   logic       done;
   logic       rejected;

   // line levels: bit 1 SCL, bit 0 SDA
   function automatic logic [1:0] drive_lines(input logic [2:0] cmd, input logic [1:0] ph,
                                              input logic [3:0] bi, input logic [7:0] sb,
                                              input logic ack, input logic [1:0] cur);
      logic       scl;
      logic [1:0] lv;
      scl = (ph == PH_HIGH);
      case (cmd)
         OP_START: begin
            lv = (ph == PH_SETUP) ? 2'b11 : ((ph == PH_HIGH) ? 2'b10 : 2'b00);
         end
         OP_STOP: begin
            lv = (ph == PH_SETUP) ? 2'b00 : ((ph == PH_HIGH) ? 2'b10 : 2'b11);
         end
         OP_WRITE: begin
            lv = {scl, (bi < ACK_BIT) ? sb[7] : 1'b1};
         end
         OP_READ: begin
            lv = {scl, (bi < ACK_BIT) ? 1'b1 : ~ack};
         end
         default: begin
            lv = cur;
         end
      endcase
      return lv;
   endfunction

   assign limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
   assign is_cmd   = (op inside {OP_START, OP_STOP, OP_WRITE, OP_READ});
   assign byte_cmd = (cmd_ff inside {OP_WRITE, OP_READ});

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      lines_in = lines_ff;
      ackc_in  = ackc_ff;
      acks_in  = acks_ff;
      rdh_in   = rdh_ff;
      done     = 1'b0;
      rejected = 1'b0;
      if (cmd_ff == CMD_IDLE) begin
         if (is_cmd) begin
            cmd_in   = op;
            phase_in = PH_SETUP;
            bit_in   = 4'd0;
            tick_in  = 8'd0;
            shift_in = (op == OP_WRITE) ? wr_data : 8'd0;
            ackc_in  = send_ack;
            lines_in = drive_lines(op, PH_SETUP, 4'd0, shift_in, send_ack, lines_ff);
         end
      end else if (is_cmd) begin
         rejected = 1'b1;
      end else begin
         tick_in = tick_ff + 8'd1;
         if (tick_in >= limit) begin
            tick_in = 8'd0;
            // sample at the end of SCL high
            if (byte_cmd && phase_ff == PH_HIGH) begin
               if (cmd_ff == OP_READ && bit_ff < ACK_BIT) begin
                  shift_in = {shift_ff[6:0], sda_in};
               end else if (cmd_ff == OP_WRITE && bit_ff >= ACK_BIT) begin
                  acks_in = sda_in;
               end
            end
            if (phase_ff != PH_LOW) begin
               phase_in = phase_ff + 2'd1;
               lines_in = drive_lines(cmd_ff, phase_in, bit_ff, shift_in, ackc_ff, lines_ff);
            end else if (!byte_cmd || bit_ff >= ACK_BIT) begin
               if (cmd_ff == OP_READ) begin
                  rdh_in = shift_in;
               end
               cmd_in   = CMD_IDLE;
               phase_in = PH_SETUP;
               bit_in   = 4'd0;
               done     = 1'b1;
            end else begin
               bit_in = bit_ff + 4'd1;
               if (cmd_ff == OP_WRITE) begin
                  shift_in = {shift_in[6:0], 1'b0};
               end
               phase_in = PH_SETUP;
               lines_in = drive_lines(cmd_ff, PH_SETUP, bit_in, shift_in, ackc_ff, lines_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= CMD_IDLE;
         phase_ff <= PH_SETUP;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         tick_ff  <= 8'd0;
         lines_ff <= 2'b11;
         ackc_ff  <= 1'b0;
         acks_ff  <= 1'b0;
         rdh_ff   <= 8'd0;
      end else if (item_accept) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
         lines_ff <= lines_in;
         ackc_ff  <= ackc_in;
         acks_ff  <= acks_in;
         rdh_ff   <= rdh_in;
      end
   end

   assign rsp.scl_out      = lines_in[1];
   assign rsp.sda_out      = lines_in[0];
   assign rsp.busy_res     = (cmd_in != CMD_IDLE);
   assign rsp.done_res     = done;
   assign rsp.rd_data      = rdh_in;
   assign rsp.ack_missing  = acks_in;
   assign rsp.cmd_rejected = rejected;

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_IDLE) |-> (phase_ff == PH_SETUP && bit_ff == 4'd0 && tick_ff == 8'd0))
      else $error("idle with sequencer counters not cleared");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (bit_ff <= ACK_BIT) && (phase_ff != 2'd3))
      else $error("bit or phase index out of range");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (item_accept && rejected) |=> ($stable(cmd_ff) && $stable(phase_ff) && $stable(tick_ff)))
      else $error("rejected command changed the sequencer");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (item_accept && done) |=> (cmd_ff == CMD_IDLE))
      else $error("command finished but engine not idle");

endmodule

/* rtl/core/i2c_master_byte_engine.sv */
// The sequencer steps at most one line phase per item; results are registered for rsp.
// Throughput: one item per cycle while the skid entry is empty (req_tready high).
// A two-entry output stage keeps accepting while one result waits for rsp_tready.
// Reset (synchronous, active high): idle, lines released high, phase_ticks = 1,
// received byte and ack status cleared, output stage empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: single-master I2C byte engine
// Stream front end, configuration register and output skid around the sequencer.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // wr_data[7:0], send_ack[8], sda_in[9], zero[15:10]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                    // rd_data[11:4], ack_missing[12], cmd_rejected[13],
                                    // zero[15:14]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import i2cm_pkg::*;

   logic [7:0] ticks_ff;
   logic       accept;
   rsp_type    seq_rsp;
   rsp_type    out_ff;
   rsp_type    skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       out_free;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else if (csr_wr_en) begin
         ticks_ff <= csr_wr_data;
      end
   end

   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .op          (req_tuser),
      .wr_data     (req_tdata[7:0]),
      .send_ack    (req_tdata[8]),
      .sda_in      (req_tdata[9]),
      .phase_ticks (ticks_ff),
      .rsp         (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : seq_rsp;
      end else if (accept) begin
         skid_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with output register empty");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to output");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && accept) |=> skid_valid_ff)
      else $error("item accepted under stall but not held");

endmodule
